// ===== src/bridge_adc_serial_reader_assert.svh =====
// Assertion macros for the bridge converter readout block.
`ifndef BRIDGE_ADC_SERIAL_READER_ASSERT_SVH
`define BRIDGE_ADC_SERIAL_READER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BSR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bsr assertion failed");
`define BSR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bsr assertion failed");
`else
`define BSR_ASSERT(lbl, clk, rst, prop)
`define BSR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/bsr_pkg.sv =====
// Package with types, constants and helpers of the bridge converter readout block.
`default_nettype none
package bsr_pkg;
   localparam int CHANNELS   = 4;
   localparam int DATA_BITS  = 24;
   localparam int VAL_W      = 48;
   localparam int SCALE_W    = 32;
   localparam int SUM_W      = 32;
   localparam int AVG_W      = 25;
   localparam int DIFF_W     = 26;
   localparam int NUM_W      = 57;
   localparam int DIV_CNT_W  = $clog2(NUM_W);
   localparam int ELAPSED_W  = 11;
   localparam int BITCNT_W   = 5;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 11'd2047;
   localparam logic [ELAPSED_W-1:0] LIM_FAST     = 11'd20;
   localparam logic [ELAPSED_W-1:0] LIM_SLOW     = 11'd150;
   localparam logic [ELAPSED_W-1:0] LIM_FAST_CAL = 11'd150;
   localparam logic [ELAPSED_W-1:0] LIM_SLOW_CAL = 11'd850;
   localparam logic [ELAPSED_W-1:0] SETTLE_FAST  = 11'd55;
   localparam logic [ELAPSED_W-1:0] SETTLE_SLOW  = 11'd405;

   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_AVERAGE = 3'd1;
   localparam logic [2:0] CMD_OFFSET  = 3'd2;
   localparam logic [2:0] CMD_UNITS   = 3'd3;
   localparam logic [2:0] CMD_TARE    = 3'd4;

   localparam logic [1:0] ERR_OK         = 2'd0;
   localparam logic [1:0] ERR_TIMEOUT_HI = 2'd1;
   localparam logic [1:0] ERR_TIMEOUT_LO = 2'd2;
   localparam logic [1:0] ERR_DIV_ZERO   = 2'd3;

   localparam logic [2:0] CSR_SPEED  = 3'd0;
   localparam logic [2:0] CSR_GAIN   = 3'd1;
   localparam logic [2:0] CSR_POWER  = 3'd2;
   localparam logic [2:0] CSR_SCALE1 = 3'd3;
   localparam logic [2:0] CSR_SCALE4 = 3'd6;

   typedef enum logic [2:0] {
      PH_IDLE, PH_WAIT_HI, PH_WAIT_LO, PH_CLK_HI, PH_CLK_LO
   } seq_phase_type;

   typedef enum logic [2:0] {
      CS_STEP, CS_AVG_GO, CS_AVG_WAIT, CS_UNIT_GO, CS_UNIT_WAIT
   } ctl_state_type;

   typedef struct packed {
      logic              sclk_level;
      logic              sel_a0;
      logic              sel_a1;
      logic [1:0]        gain_pins;
      logic              speed_pin;
      logic              power_pin;
      logic              busy_res;
      logic              done_res;
      logic [1:0]        error_code;
      logic [VAL_W-1:0]  result_value;
   } rsp_item_type;

   function automatic logic [ELAPSED_W-1:0] base_limit(input logic fast, input logic cal);
      logic [ELAPSED_W-1:0] lim;
      if (cal) begin
         lim = fast ? LIM_FAST_CAL : LIM_SLOW_CAL;
      end else begin
         lim = fast ? LIM_FAST : LIM_SLOW;
      end
      return lim;
   endfunction
endpackage
`default_nettype wire

// ===== src/bsr_if.sv =====
// Channel interfaces of the bridge converter readout block.
`default_nettype none
interface bsr_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic       dout_level;
   logic       ms_tick;
   logic [2:0] channel;
   logic       calibrating;
   logic [7:0] sample_count;
   modport source (output valid, command, dout_level, ms_tick, channel, calibrating,
                   sample_count, input ready);
   modport sink (input valid, command, dout_level, ms_tick, channel, calibrating,
                 sample_count, output ready);
endinterface

interface bsr_rsp_if;
   logic        valid;
   logic        ready;
   logic        sclk_level;
   logic        sel_a0;
   logic        sel_a1;
   logic [1:0]  gain_pins;
   logic        speed_pin;
   logic        power_pin;
   logic        busy_res;
   logic        done_res;
   logic [1:0]  error_code;
   logic signed [47:0] result_value;
   modport source (output valid, sclk_level, sel_a0, sel_a1, gain_pins, speed_pin,
                   power_pin, busy_res, done_res, error_code, result_value, input ready);
   modport sink (input valid, sclk_level, sel_a0, sel_a1, gain_pins, speed_pin,
                 power_pin, busy_res, done_res, error_code, result_value, output ready);
endinterface

interface bsr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/bsr_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module bsr_divider
   import bsr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [NUM_W-1:0]   dividend,
   input  wire logic [SCALE_W-1:0] divisor,
   output logic                    busy,
   output logic                    done,
   output logic [NUM_W-1:0]        quotient
);
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [SCALE_W:0]     rem_ff, rem_in;
   logic [SCALE_W-1:0]   dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [SCALE_W:0]     rem_shift;
   logic [SCALE_W+1:0]   trial;
   logic                 ge;

   always_comb begin
      rem_shift = {rem_ff[SCALE_W-1:0], quo_ff[NUM_W-1]};
      trial     = {1'b0, rem_shift} - {2'b00, dvs_ff};
      ge        = !trial[SCALE_W+1];
      rem_in    = ge ? trial[SCALE_W:0] : rem_shift;
      quo_in    = {quo_ff[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == DIV_CNT_W'(NUM_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            quo_ff  <= quo_in;
            rem_ff  <= rem_in;
            cnt_ff  <= cnt_ff + 1'b1;
            busy_ff <= (cnt_ff != DIV_CNT_W'(NUM_W - 1));
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ===== src/bridge_adc_serial_reader.sv =====
// An accepted slot's result is registered and offered in the next cycle; a slot that
// ends a request first goes through the average division and, for units, the units
// division. One slot a cycle, except while the serial divider works on a finish or a
// result waits unaccepted. Reset clears the sequencer, offsets, channel memory and
// restores register defaults. Top level of the bridge converter readout block.
`default_nettype none
`include "bridge_adc_serial_reader_assert.svh"
module bridge_adc_serial_reader
   import bsr_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   bsr_req_if.sink   req_if,
   bsr_rsp_if.source rsp_if,
   bsr_csr_if.sink   csr_if
);
   logic                 speed_ff, power_ff;
   logic [1:0]           gain_ff;
   logic [SCALE_W-1:0]   scale_ff [CHANNELS];
   logic signed [DATA_BITS-1:0] offs_ff [CHANNELS];

   seq_phase_type        phase_ff, phase_in;
   ctl_state_type        ctl_ff, ctl_in;
   logic [2:0]           last_ch_ff, last_ch_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [BITCNT_W-1:0]  bitcnt_ff, bitcnt_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in, limit_ff, limit_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [7:0]           samples_ff, samples_in;
   logic [2:0]           lat_cmd_ff, lat_cmd_in, lat_ch_ff, lat_ch_in;
   logic                 lat_cal_ff, lat_cal_in;
   logic [7:0]           lat_cnt_ff, lat_cnt_in;
   logic signed [DIFF_W-1:0] diff_ff;

   rsp_item_type         rsp_ff, step_item;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_fire, rsp_fire, finish;
   logic [BITCNT_W-1:0]  bit_next;
   logic [ELAPSED_W-1:0] el_inc;
   logic [1:0]           pin_idx, lat_idx;

   logic                 div_start, div_busy, div_done;
   logic [NUM_W-1:0]     div_dividend, div_q;
   logic [SCALE_W-1:0]   div_divisor;
   logic [SUM_W-1:0]     sum_mag;
   logic [DIFF_W-1:0]    diff_mag;
   logic signed [AVG_W-1:0]  avg;
   logic signed [DIFF_W-1:0] diff;
   logic signed [VAL_W-1:0]  units;

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;
   assign lat_idx  = 2'(lat_ch_ff - 3'd1);
   assign csr_if.ready = 1'b1;

   // sequencer step for one pin slot
   always_comb begin
      phase_in   = phase_ff;
      last_ch_in = last_ch_ff;
      shift_in   = shift_ff;
      bitcnt_in  = bitcnt_ff;
      elapsed_in = elapsed_ff;
      limit_in   = limit_ff;
      sum_in     = sum_ff;
      samples_in = samples_ff;
      lat_cmd_in = lat_cmd_ff;
      lat_ch_in  = lat_ch_ff;
      lat_cal_in = lat_cal_ff;
      lat_cnt_in = lat_cnt_ff;
      finish     = 1'b0;
      step_item  = '0;
      bit_next   = bitcnt_ff + 1'b1;
      el_inc     = (elapsed_ff < ELAPSED_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
      if (!power_ff) begin
         step_item.sclk_level = 1'b1;
         step_item.busy_res   = (phase_ff != PH_IDLE);
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (req_if.command >= CMD_AVERAGE && req_if.command <= CMD_TARE &&
                   req_if.channel >= 3'd1 && req_if.channel <= 3'(CHANNELS)) begin
                  lat_cmd_in = req_if.command;
                  lat_ch_in  = req_if.channel;
                  lat_cal_in = req_if.calibrating;
                  lat_cnt_in = req_if.sample_count;
                  step_item.busy_res = 1'b1;
                  if (req_if.sample_count == 8'd0) begin
                     step_item.done_res   = 1'b1;
                     step_item.error_code = ERR_DIV_ZERO;
                  end else begin
                     limit_in = base_limit(speed_ff, req_if.calibrating);
                     if (req_if.channel != last_ch_ff) begin
                        limit_in = limit_in + (speed_ff ? SETTLE_FAST : SETTLE_SLOW);
                     end
                     last_ch_in = req_if.channel;
                     samples_in = '0;
                     sum_in     = '0;
                     elapsed_in = '0;
                     phase_in   = PH_WAIT_HI;
                  end
               end
            end
            PH_WAIT_HI, PH_WAIT_LO: begin
               step_item.busy_res = 1'b1;
               if (req_if.dout_level == (phase_ff == PH_WAIT_HI)) begin
                  elapsed_in = '0;
                  if (phase_ff == PH_WAIT_HI) begin
                     phase_in = PH_WAIT_LO;
                  end else begin
                     phase_in  = PH_CLK_HI;
                     bitcnt_in = '0;
                     shift_in  = '0;
                  end
               end else if (req_if.ms_tick) begin
                  elapsed_in = el_inc;
                  if (el_inc > limit_ff) begin
                     step_item.done_res   = 1'b1;
                     step_item.error_code = (phase_ff == PH_WAIT_HI) ? ERR_TIMEOUT_HI
                                                                     : ERR_TIMEOUT_LO;
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_CLK_HI: begin
               step_item.busy_res   = 1'b1;
               step_item.sclk_level = 1'b1;
               phase_in = PH_CLK_LO;
            end
            PH_CLK_LO: begin
               step_item.busy_res = 1'b1;
               if (bitcnt_ff < BITCNT_W'(DATA_BITS)) begin
                  shift_in = {shift_ff[DATA_BITS-2:0], req_if.dout_level};
               end
               bitcnt_in = bit_next;
               if (bit_next < BITCNT_W'(DATA_BITS) + (lat_cal_ff ? 5'd2 : 5'd1)) begin
                  phase_in = PH_CLK_HI;
               end else begin
                  sum_in     = sum_ff + SUM_W'(signed'(shift_in));
                  samples_in = samples_ff + 1'b1;
                  if (samples_in < lat_cnt_ff) begin
                     limit_in   = base_limit(speed_ff, lat_cal_ff);
                     elapsed_in = '0;
                     phase_in   = PH_WAIT_HI;
                  end else begin
                     step_item.done_res = 1'b1;
                     finish   = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      pin_idx = (last_ch_in != 3'd0) ? 2'(last_ch_in - 3'd1) : 2'd0;
      step_item.sel_a0    = pin_idx[0];
      step_item.sel_a1    = pin_idx[1];
      step_item.gain_pins = gain_ff;
      step_item.speed_pin = speed_ff;
      step_item.power_pin = power_ff;
   end

   // finish arithmetic around the divider
   always_comb begin
      sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      avg      = sum_ff[SUM_W-1] ? -signed'(div_q[AVG_W-1:0]) : signed'(div_q[AVG_W-1:0]);
      diff     = DIFF_W'(avg) - DIFF_W'(offs_ff[lat_idx]);
      diff_mag = diff_ff[DIFF_W-1] ? DIFF_W'(-diff_ff) : DIFF_W'(diff_ff);
      if (!diff_ff[DIFF_W-1]) begin
         units = (div_q > NUM_W'({1'b0, {(VAL_W-1){1'b1}}})) ? {1'b0, {(VAL_W-1){1'b1}}}
                                                               : signed'(div_q[VAL_W-1:0]);
      end else begin
         units = (div_q > NUM_W'({1'b1, {(VAL_W-1){1'b0}}})) ? {1'b1, {(VAL_W-1){1'b0}}}
                                                               : -signed'(div_q[VAL_W-1:0]);
      end
   end

   always_comb begin
      ctl_in = ctl_ff;
      case (ctl_ff)
         CS_STEP:      if (req_fire && finish) ctl_in = CS_AVG_GO;
         CS_AVG_GO:    ctl_in = CS_AVG_WAIT;
         CS_AVG_WAIT: begin
            if (div_done) begin
               ctl_in = (lat_cmd_ff == CMD_UNITS && scale_ff[lat_idx] != '0) ? CS_UNIT_GO
                                                                             : CS_STEP;
            end
         end
         CS_UNIT_GO:   ctl_in = CS_UNIT_WAIT;
         CS_UNIT_WAIT: if (div_done) ctl_in = CS_STEP;
         default:      ctl_in = CS_STEP;
      endcase
   end

   always_comb begin
      div_start    = (ctl_ff == CS_AVG_GO) || (ctl_ff == CS_UNIT_GO);
      div_dividend = NUM_W'(sum_mag);
      div_divisor  = SCALE_W'(lat_cnt_ff);
      if (ctl_ff == CS_UNIT_GO) begin
         div_dividend = {diff_mag[NUM_W-SCALE_W-1:0], {SCALE_W{1'b0}}};
         div_divisor  = scale_ff[lat_idx];
      end
      req_if.ready = (ctl_ff == CS_STEP) && (!rsp_valid_ff || rsp_if.ready);
      rsp_valid_in = rsp_valid_ff;
      if (rsp_fire) rsp_valid_in = 1'b0;
      if (req_fire) rsp_valid_in = !finish;
      if (ctl_ff == CS_AVG_WAIT && div_done &&
          !(lat_cmd_ff == CMD_UNITS && scale_ff[lat_idx] != '0)) begin
         rsp_valid_in = 1'b1;
      end
      if (ctl_ff == CS_UNIT_WAIT && div_done) rsp_valid_in = 1'b1;
   end

   bsr_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= 1'b1;
         gain_ff      <= 2'd3;
         power_ff     <= 1'b1;
         for (int i = 0; i < CHANNELS; i++) begin
            scale_ff[i] <= SCALE_W'(65536);
            offs_ff[i]  <= '0;
         end
         phase_ff     <= PH_IDLE;
         ctl_ff       <= CS_STEP;
         last_ch_ff   <= '0;
         shift_ff     <= '0;
         bitcnt_ff    <= '0;
         elapsed_ff   <= '0;
         limit_ff     <= '0;
         sum_ff       <= '0;
         samples_ff   <= '0;
         lat_cmd_ff   <= '0;
         lat_ch_ff    <= '0;
         lat_cal_ff   <= 1'b0;
         lat_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid) begin
            case (csr_if.index)
               CSR_SPEED: speed_ff <= csr_if.data[0];
               CSR_GAIN:  gain_ff  <= csr_if.data[1:0];
               CSR_POWER: power_ff <= csr_if.data[0];
               default: begin
                  if (csr_if.index >= CSR_SCALE1 && csr_if.index <= CSR_SCALE4) begin
                     scale_ff[2'(csr_if.index - CSR_SCALE1)] <= csr_if.data;
                  end
               end
            endcase
         end
         if (req_fire) begin
            phase_ff   <= phase_in;
            last_ch_ff <= last_ch_in;
            shift_ff   <= shift_in;
            bitcnt_ff  <= bitcnt_in;
            elapsed_ff <= elapsed_in;
            limit_ff   <= limit_in;
            sum_ff     <= sum_in;
            samples_ff <= samples_in;
            lat_cmd_ff <= lat_cmd_in;
            lat_ch_ff  <= lat_ch_in;
            lat_cal_ff <= lat_cal_in;
            lat_cnt_ff <= lat_cnt_in;
            rsp_ff     <= step_item;
         end
         if (ctl_ff == CS_AVG_WAIT && div_done) begin
            diff_ff <= diff;
            case (lat_cmd_ff)
               CMD_OFFSET: begin
                  rsp_ff.result_value <= VAL_W'(diff);
               end
               CMD_UNITS: begin
                  if (scale_ff[lat_idx] == '0) begin
                     rsp_ff.error_code   <= ERR_DIV_ZERO;
                     rsp_ff.result_value <= '0;
                  end
               end
               CMD_TARE: begin
                  offs_ff[lat_idx]    <= avg[DATA_BITS-1:0];
                  rsp_ff.result_value <= VAL_W'(avg);
               end
               default: begin
                  rsp_ff.result_value <= VAL_W'(avg);
               end
            endcase
         end
         if (ctl_ff == CS_UNIT_WAIT && div_done) begin
            rsp_ff.result_value <= units;
         end
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sclk_level   = rsp_ff.sclk_level;
   assign rsp_if.sel_a0       = rsp_ff.sel_a0;
   assign rsp_if.sel_a1       = rsp_ff.sel_a1;
   assign rsp_if.gain_pins    = rsp_ff.gain_pins;
   assign rsp_if.speed_pin    = rsp_ff.speed_pin;
   assign rsp_if.power_pin    = rsp_ff.power_pin;
   assign rsp_if.busy_res     = rsp_ff.busy_res;
   assign rsp_if.done_res     = rsp_ff.done_res;
   assign rsp_if.error_code   = rsp_ff.error_code;
   assign rsp_if.result_value = signed'(rsp_ff.result_value);

   `BSR_ASSERT(a_err_zero_val, clock, reset, rsp_valid_ff && rsp_ff.error_code != ERR_OK |-> rsp_ff.result_value == '0)
   `BSR_ASSERT(a_done_busy, clock, reset, rsp_valid_ff && rsp_ff.done_res |-> rsp_ff.busy_res)
   `BSR_ASSERT(a_div_owner, clock, reset, div_busy |-> (ctl_ff == CS_AVG_WAIT || ctl_ff == CS_UNIT_WAIT))
   `BSR_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid_ff && ctl_ff == CS_STEP)
endmodule
`default_nettype wire

// ===== tb/sv/bridge_adc_serial_reader_test.sv =====
// Self-checking testbench for the bridge converter serial readout block.
`timescale 1ns / 1ps
module bridge_adc_serial_reader_test;
   import bsr_pkg::*;

   typedef struct {
      logic [2:0] command;
      logic       dout_level;
      logic       ms_tick;
      logic [2:0] channel;
      logic       calibrating;
      logic [7:0] sample_count;
   } pin_slot_type;

   localparam longint SAT_MAX = 64'sd140737488355327;
   localparam longint SAT_MIN = -64'sd140737488355328;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bsr_req_if req_ch();
   bsr_rsp_if rsp_ch();
   bsr_csr_if csr_ch();

   bridge_adc_serial_reader u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #5 clock = ~clock;

   // register copies
   logic        cfg_fast = 1'b1;
   logic [1:0]  cfg_gain = 2'd3;
   logic        cfg_power = 1'b1;
   logic [31:0] cfg_scale [4] = '{32'd65536, 32'd65536, 32'd65536, 32'd65536};

   // sequencer copies
   seq_phase_type       phase = PH_IDLE;
   logic [2:0]          prev_channel = '0;
   int                  offsets [4] = '{0, 0, 0, 0};
   logic [23:0]         shifter = '0;
   logic [4:0]          bits_seen = '0;
   logic [10:0]         elapsed_ms = '0;
   logic [10:0]         wait_limit = '0;
   longint              sample_sum = 0;
   logic [7:0]          samples_taken = '0;
   logic [2:0]          held_cmd = '0;
   logic [2:0]          held_ch = '0;
   logic                held_cal = 1'b0;
   logic [7:0]          held_cnt = '0;

   pin_slot_type  slot_q [$];
   rsp_item_type  expected_pins_q [$];
   pin_slot_type  cur_slot;

   int  n_errors = 0;
   int  n_slots = 0;
   int  n_done = 0;
   int  n_err_code [4] = '{0, 0, 0, 0};
   int  n_requests = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   int  hold_left = 0;
   int  stall_pct = 0;
   int  stall_age = 0;
   int  quiet_cycles = 0;
   logic hold_req = 1'b0;
   logic hold_taken = 1'b0;
   logic sender_paused = 1'b0;

   function automatic logic [10:0] wait_base(input logic cal);
      if (cal) return cfg_fast ? LIM_FAST_CAL : LIM_SLOW_CAL;
      return cfg_fast ? LIM_FAST : LIM_SLOW;
   endfunction

   function automatic rsp_item_type predict_slot(input pin_slot_type s);
      rsp_item_type r;
      logic         sclk;
      logic         busy;
      logic         done;
      logic [1:0]   err;
      longint       val;
      longint       avg;
      longint       diff;
      longint       q;
      int           idx;
      logic [4:0]   prev_bits;
      sclk = 1'b0;
      busy = 1'b0;
      done = 1'b0;
      err = ERR_OK;
      val = 0;
      if (!cfg_power) begin
         sclk = 1'b1;
         busy = (phase != PH_IDLE);
      end else begin
         case (phase)
            PH_IDLE: begin
               if (s.command >= CMD_AVERAGE && s.command <= CMD_TARE &&
                   s.channel >= 3'd1 && s.channel <= 3'd4) begin
                  held_cmd = s.command;
                  held_ch = s.channel;
                  held_cal = s.calibrating;
                  held_cnt = s.sample_count;
                  busy = 1'b1;
                  if (s.sample_count == 8'd0) begin
                     done = 1'b1;
                     err = ERR_DIV_ZERO;
                  end else begin
                     wait_limit = wait_base(s.calibrating);
                     if (s.channel != prev_channel)
                        wait_limit = wait_limit + (cfg_fast ? SETTLE_FAST : SETTLE_SLOW);
                     prev_channel = s.channel;
                     samples_taken = '0;
                     sample_sum = 0;
                     elapsed_ms = '0;
                     phase = PH_WAIT_HI;
                  end
               end
            end
            PH_WAIT_HI, PH_WAIT_LO: begin
               busy = 1'b1;
               if (s.dout_level == (phase == PH_WAIT_HI)) begin
                  elapsed_ms = '0;
                  if (phase == PH_WAIT_HI) begin
                     phase = PH_WAIT_LO;
                  end else begin
                     phase = PH_CLK_HI;
                     bits_seen = '0;
                     shifter = '0;
                  end
               end else if (s.ms_tick) begin
                  if (elapsed_ms < ELAPSED_MAX) elapsed_ms = elapsed_ms + 11'd1;
                  if (elapsed_ms > wait_limit) begin
                     done = 1'b1;
                     err = (phase == PH_WAIT_HI) ? ERR_TIMEOUT_HI : ERR_TIMEOUT_LO;
                     phase = PH_IDLE;
                  end
               end
            end
            PH_CLK_HI: begin
               busy = 1'b1;
               sclk = 1'b1;
               phase = PH_CLK_LO;
            end
            PH_CLK_LO: begin
               busy = 1'b1;
               prev_bits = bits_seen;
               if (prev_bits < 5'd24) shifter = {shifter[22:0], s.dout_level};
               bits_seen = bits_seen + 5'd1;
               if (bits_seen < (held_cal ? 5'd26 : 5'd25)) begin
                  phase = PH_CLK_HI;
               end else begin
                  sample_sum = sample_sum + longint'($signed(shifter));
                  samples_taken = samples_taken + 8'd1;
                  if (samples_taken < held_cnt) begin
                     wait_limit = wait_base(held_cal);
                     elapsed_ms = '0;
                     phase = PH_WAIT_HI;
                  end else begin
                     done = 1'b1;
                     phase = PH_IDLE;
                     idx = int'(held_ch) - 1;
                     avg = sample_sum / longint'(int'(held_cnt));
                     diff = avg - longint'(offsets[idx]);
                     case (held_cmd)
                        CMD_AVERAGE: val = avg;
                        CMD_OFFSET: val = diff;
                        CMD_UNITS: begin
                           if (cfg_scale[idx] == 32'd0) begin
                              err = ERR_DIV_ZERO;
                           end else begin
                              q = (diff * 64'sd4294967296) / longint'({32'b0, cfg_scale[idx]});
                              if (q > SAT_MAX) q = SAT_MAX;
                              if (q < SAT_MIN) q = SAT_MIN;
                              val = q;
                           end
                        end
                        default: begin
                           offsets[idx] = int'(avg);
                           val = avg;
                        end
                     endcase
                  end
               end
            end
            default: phase = PH_IDLE;
         endcase
      end
      if (err != ERR_OK) val = 0;
      idx = (prev_channel >= 3'd1) ? int'(prev_channel) - 1 : 0;
      r.sclk_level = sclk;
      r.sel_a0 = idx[0];
      r.sel_a1 = idx[1];
      r.gain_pins = cfg_gain;
      r.speed_pin = cfg_fast;
      r.power_pin = cfg_power;
      r.busy_res = busy;
      r.done_res = done;
      r.error_code = err;
      r.result_value = val[47:0];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [47:0] got,
                                  input logic [47:0] want);
      n_errors++;
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
   endtask

   task automatic push_slot(input logic dout, input logic tick);
      pin_slot_type s;
      s.command = 3'($urandom_range(0, 7));
      s.dout_level = dout;
      s.ms_tick = tick;
      s.channel = 3'($urandom_range(0, 7));
      s.calibrating = 1'($urandom);
      s.sample_count = 8'($urandom);
      slot_q.push_back(s);
   endtask

   // fail: 0 completes, 1 stalls with DOUT low, 2 stalls with DOUT high
   task automatic add_request(input logic [2:0] cmd, input logic [2:0] ch, input logic cal,
                              input logic [7:0] cnt, input int fail, input bit rnd_data,
                              input logic [23:0] data);
      pin_slot_type s;
      logic [23:0]  smp;
      int           n;
      s.command = cmd;
      s.dout_level = 1'($urandom);
      s.ms_tick = 1'($urandom);
      s.channel = ch;
      s.calibrating = cal;
      s.sample_count = cnt;
      slot_q.push_back(s);
      n_requests++;
      if (cnt == 8'd0 || cmd < CMD_AVERAGE || cmd > CMD_TARE || ch < 3'd1 || ch > 3'd4)
         return;
      n = 80;
      if (fail == 1) begin
         repeat (n) push_slot(1'b0, 1'b1);
         return;
      end
      if (fail == 2) begin
         push_slot(1'b1, 1'($urandom));
         repeat (n) push_slot(1'b1, 1'b1);
         return;
      end
      repeat (cnt) begin
         smp = rnd_data ? 24'($urandom) : data;
         repeat ($urandom_range(0, 3)) push_slot(1'b0, ($urandom_range(0, 7) == 0));
         repeat ($urandom_range(1, 2)) push_slot(1'b1, ($urandom_range(0, 7) == 0));
         repeat ($urandom_range(1, 2)) push_slot(1'b0, 1'($urandom));
         for (int i = 0; i < (cal ? 26 : 25); i++) begin
            push_slot(1'($urandom), 1'($urandom));
            push_slot((i < 24) ? smp[23 - i] : 1'($urandom), 1'($urandom));
         end
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (slot_q.size() != 0 || req_ch.valid || expected_pins_q.size() != 0);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= data;
      do @(posedge clock);
      while (!csr_ch.ready);
      case (index)
         CSR_SPEED: cfg_fast = data[0];
         CSR_GAIN: cfg_gain = data[1:0];
         CSR_POWER: cfg_power = data[0];
         default: cfg_scale[index - CSR_SCALE1] = data;
      endcase
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_request();
      int          pick;
      logic [2:0]  cmd;
      logic [7:0]  cnt;
      pick = $urandom_range(0, 99);
      cmd = 3'($urandom_range(CMD_AVERAGE, CMD_TARE));
      cnt = (pick < 85) ? 8'($urandom_range(1, 2)) : 8'($urandom_range(0, 3));
      if (pick < 4)
         add_request(cmd, 3'($urandom_range(1, 4)), 1'($urandom), cnt, 1, 1, '0);
      else if (pick < 8)
         add_request(cmd, 3'($urandom_range(1, 4)), 1'($urandom), cnt, 2, 1, '0);
      else if (pick < 11)
         add_request(3'($urandom_range(5, 7)), 3'($urandom_range(0, 7)), 1'($urandom),
                     cnt, 0, 1, '0);
      else if (pick < 14)
         add_request(cmd, ($urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(5, 7))),
                     1'($urandom), cnt, 0, 1, '0);
      else
         add_request(cmd, 3'($urandom_range(1, 4)), 1'($urandom), cnt, 0, 1, '0);
   endtask

   initial begin
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_SPEED;
      csr_ch.data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, every error path
      add_request(CMD_AVERAGE, 3'd1, 1'b0, 8'd1, 0, 0, 24'h7FFFFF);
      add_request(CMD_AVERAGE, 3'd2, 1'b1, 8'd2, 0, 0, 24'h800000);
      add_request(CMD_TARE, 3'd3, 1'b0, 8'd1, 0, 0, 24'h123456);
      add_request(CMD_OFFSET, 3'd3, 1'b0, 8'd1, 0, 0, 24'h000001);
      add_request(CMD_UNITS, 3'd3, 1'b0, 8'd1, 0, 0, 24'hFFFFFF);
      add_request(CMD_UNITS, 3'd4, 1'b1, 8'd0, 0, 0, '0);
      add_request(3'd5, 3'd1, 1'b0, 8'd1, 0, 0, '0);
      add_request(3'd7, 3'd4, 1'b0, 8'd1, 0, 0, '0);
      add_request(CMD_AVERAGE, 3'd0, 1'b0, 8'd1, 0, 0, '0);
      add_request(CMD_AVERAGE, 3'd7, 1'b0, 8'd1, 0, 0, '0);
      add_request(CMD_AVERAGE, 3'd4, 1'b0, 8'd1, 1, 0, '0);
      add_request(CMD_OFFSET, 3'd1, 1'b0, 8'd1, 2, 0, '0);
      wait_idle();

      // slow rate, lowest gain, scale extremes
      csr_write(CSR_SPEED, 32'd0);
      csr_write(CSR_GAIN, 32'd0);
      csr_write(CSR_SCALE1, 32'd0);
      csr_write(CSR_SCALE1 + 3'd1, 32'd1);
      csr_write(CSR_SCALE1 + 3'd2, 32'hFFFFFFFF);
      csr_write(CSR_SCALE4, $urandom);
      add_request(CMD_UNITS, 3'd1, 1'b0, 8'd1, 0, 1, '0);
      add_request(CMD_UNITS, 3'd2, 1'b0, 8'd1, 0, 0, 24'h7FFFFF);
      add_request(CMD_UNITS, 3'd2, 1'b0, 8'd1, 0, 0, 24'h800000);
      wait_idle();

      // powered down: requests ignored, clock held high
      csr_write(CSR_POWER, 32'd0);
      repeat (20) push_slot(1'($urandom), 1'($urandom));
      wait_idle();
      csr_write(CSR_POWER, 32'd1);
      csr_write(CSR_SPEED, 32'd1);
      csr_write(CSR_GAIN, 32'd2);

      for (int k = 0; k < 3; k++) begin
         if (k == 0) begin
            @(posedge clock);
            hold_req <= 1'b1;
         end
         if (k == 1) begin
            @(posedge clock);
            sender_paused <= 1'b1;
            do @(posedge clock);
            while (expected_pins_q.size() != 0);
            sender_paused <= 1'b0;
         end
         if (k == 2) begin
            wait_idle();
            csr_write(CSR_GAIN, 32'd1);
            for (int c = 0; c < 4; c++)
               csr_write(CSR_SCALE1 + 3'(c), $urandom_range(0, 3) == 0 ? $urandom :
                         $urandom_range(1, 32'h40000));
         end
         random_request();
      end
      wait_idle();

      $display("Covered %0d slots and %0d requests, %0d finished (ok %0d, timeout high %0d,",
               n_slots, n_requests, n_done, n_err_code[0], n_err_code[1]);
      $display("timeout low %0d, divide error %0d), over two rates, power-down and scales.",
               n_err_code[2], n_err_code[3]);
      if (n_errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // drive slots in bursts
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.command <= CMD_NONE;
         req_ch.dout_level <= 1'b0;
         req_ch.ms_tick <= 1'b0;
         req_ch.channel <= '0;
         req_ch.calibrating <= 1'b0;
         req_ch.sample_count <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_pins_q.push_back(predict_slot(cur_slot));
            n_slots++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (sender_paused || slot_q.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else begin
               cur_slot = slot_q.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.command <= cur_slot.command;
               req_ch.dout_level <= cur_slot.dout_level;
               req_ch.ms_tick <= cur_slot.ms_tick;
               req_ch.channel <= cur_slot.channel;
               req_ch.calibrating <= cur_slot.calibrating;
               req_ch.sample_count <= cur_slot.sample_count;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 60);
                  gap_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // receiver stall pattern and long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = 400;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         stall_age++;
         if (stall_age >= 256) begin
            stall_age = 0;
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 20;
               default: stall_pct = 60;
            endcase
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // check results
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_pins_q.size() == 0) begin
            n_errors++;
            $display("%0t: result transaction with nothing expected", $realtime);
         end else begin
            want = expected_pins_q.pop_front();
            if (want.done_res) begin
               n_done++;
               n_err_code[want.error_code]++;
            end
            if (rsp_ch.sclk_level !== want.sclk_level)
               report_mismatch("sclk_level", 48'(rsp_ch.sclk_level), 48'(want.sclk_level));
            if (rsp_ch.sel_a0 !== want.sel_a0)
               report_mismatch("sel_a0", 48'(rsp_ch.sel_a0), 48'(want.sel_a0));
            if (rsp_ch.sel_a1 !== want.sel_a1)
               report_mismatch("sel_a1", 48'(rsp_ch.sel_a1), 48'(want.sel_a1));
            if (rsp_ch.gain_pins !== want.gain_pins)
               report_mismatch("gain_pins", 48'(rsp_ch.gain_pins), 48'(want.gain_pins));
            if (rsp_ch.speed_pin !== want.speed_pin)
               report_mismatch("speed_pin", 48'(rsp_ch.speed_pin), 48'(want.speed_pin));
            if (rsp_ch.power_pin !== want.power_pin)
               report_mismatch("power_pin", 48'(rsp_ch.power_pin), 48'(want.power_pin));
            if (rsp_ch.busy_res !== want.busy_res)
               report_mismatch("busy_res", 48'(rsp_ch.busy_res), 48'(want.busy_res));
            if (rsp_ch.done_res !== want.done_res)
               report_mismatch("done_res", 48'(rsp_ch.done_res), 48'(want.done_res));
            if (rsp_ch.error_code !== want.error_code)
               report_mismatch("error_code", 48'(rsp_ch.error_code), 48'(want.error_code));
            if (rsp_ch.result_value !== want.result_value)
               report_mismatch("result_value", rsp_ch.result_value, want.result_value);
         end
      end
   end

   // watchdog on transaction activity
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= 5000) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end
endmodule
